// ===== sv/bellman_ford_shortest_paths_assert.svh =====
// Assertion macros shared by the shortest-path block modules.
// No dependencies; included by modules that carry concurrent checks.
`ifndef BELLMAN_FORD_SHORTEST_PATHS_ASSERT_SVH
`define BELLMAN_FORD_SHORTEST_PATHS_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define BFSP_ASSERT_IMPL(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);
// Next-cycle implication checked outside reset.
`define BFSP_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`endif

// ===== sv/bfsp_pkg.sv =====
// Shared types and constants for the shortest-path block.
// No dependencies.
package bfsp_pkg;
  localparam int MaxVertices = 64;
  localparam int MaxEdges = 256;
  localparam int VW = $clog2(MaxVertices);
  localparam int EW = $clog2(MaxEdges);
  localparam int QDepth = 2;
  localparam logic signed [23:0] DistMax = 24'sh7FFFFF;
  localparam logic signed [23:0] DistMin = -24'sh800000;

  // Configuration register indexes.
  localparam logic CfgVertexCount = 1'b0;
  localparam logic CfgStartVertex = 1'b1;

  typedef struct packed {
    logic [VW-1:0] src;
    logic [VW-1:0] dst;
    logic signed [15:0] weight;
    logic present;
    logic last;
  } edge_item_t;
endpackage

// ===== sv/bfsp_front.sv =====
// Front end: accepts input transfers and queues them for the engine.
// Depends on bfsp_pkg.
module bfsp_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  bfsp_pkg::edge_item_t  in_item,
  output logic                  q_valid,
  input  logic                  q_ready,
  output bfsp_pkg::edge_item_t  q_item
);
  bfsp_pkg::edge_item_t slots [bfsp_pkg::QDepth];
  logic rd_ptr, wr_ptr;
  logic [1:0] fill;
  logic push, pop;

  assign in_ready = (fill != 2'd2);
  assign q_valid = (fill != 2'd0);
  assign q_item = slots[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

`include "bellman_ford_shortest_paths_assert.svh"
  `BFSP_ASSERT_IMPL(a_fill_range, clk, rst, 1'b1, fill <= 2'd2, "queue overfilled")
  `BFSP_ASSERT_NEXT(a_fill_push, clk, rst, push && !pop, fill == $past(fill) + 2'd1, "fill bad")
  `BFSP_ASSERT_IMPL(a_empty, clk, rst, fill == 2'd0, !q_valid, "empty queue valid")
endmodule

// ===== sv/bfsp_engine.sv =====
// Back end: edge store, relaxation sequencer and result stream.
// Depends on bfsp_pkg.
module bfsp_engine (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  bfsp_pkg::edge_item_t        q_item,
  input  logic [6:0]                  vertex_count,
  input  logic [5:0]                  start_vertex,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [5:0]                  vertex,
  output logic                        reached,
  output logic signed [23:0]          distance,
  output logic signed [6:0]           predecessor,
  output logic                        negative_cycle,
  output logic                        last_result
);
  typedef enum logic [2:0] {
    S_LOAD, S_INIT, S_FETCH, S_READ, S_RELAX, S_EMIT, S_WAIT
  } state_t;
  state_t state;

  logic [bfsp_pkg::VW-1:0] e_src [bfsp_pkg::MaxEdges];
  logic [bfsp_pkg::VW-1:0] e_dst [bfsp_pkg::MaxEdges];
  logic signed [15:0] e_wt [bfsp_pkg::MaxEdges];
  logic signed [23:0] dist_tab [bfsp_pkg::MaxVertices];
  logic [bfsp_pkg::MaxVertices-1:0] fin;
  logic signed [6:0] pred [bfsp_pkg::MaxVertices];

  logic [bfsp_pkg::EW:0] ecount, eidx;
  logic [6:0] nv, pass;
  logic [bfsp_pkg::VW:0] vidx;
  logic [bfsp_pkg::VW-1:0] ru, rv;
  logic signed [15:0] rw;
  logic signed [23:0] dist_u, dist_v;
  logic improved;
  logic signed [24:0] sum;
  logic signed [23:0] cand;
  logic ok, better, check;

  assign q_ready = (state == S_LOAD);
  assign check = (pass == nv);

  always_comb begin
    sum = 25'(dist_u) + 25'(rw);
    if (sum > 25'(bfsp_pkg::DistMax)) cand = bfsp_pkg::DistMax;
    else if (sum < 25'(bfsp_pkg::DistMin)) cand = bfsp_pkg::DistMin;
    else cand = sum[23:0];
    ok = ({1'b0, ru} < nv) && ({1'b0, rv} < nv) && fin[ru];
    better = ok && (!fin[rv] || cand < dist_v);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      ecount <= '0;
      out_valid <= 1'b0;
      fin <= '0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (q_valid) begin
            if (q_item.present && ecount < (bfsp_pkg::EW+1)'(bfsp_pkg::MaxEdges)) begin
              e_src[ecount[bfsp_pkg::EW-1:0]] <= q_item.src;
              e_dst[ecount[bfsp_pkg::EW-1:0]] <= q_item.dst;
              e_wt[ecount[bfsp_pkg::EW-1:0]] <= q_item.weight;
              ecount <= ecount + 1'b1;
            end
            if (q_item.last) begin
              if (vertex_count == 7'd0) nv <= 7'd1;
              else if (vertex_count > 7'(bfsp_pkg::MaxVertices))
                nv <= 7'(bfsp_pkg::MaxVertices);
              else nv <= vertex_count;
              state <= S_INIT;
            end
          end
        end
        S_INIT: begin
          // Only an in-range start vertex is finite; others are used once finite.
          if ({1'b0, start_vertex} < nv) begin
            fin <= {{(bfsp_pkg::MaxVertices-1){1'b0}}, 1'b1} << start_vertex;
            dist_tab[start_vertex] <= '0;
            pred[start_vertex] <= -7'sd1;
          end else begin
            fin <= '0;
          end
          pass <= 7'd1;
          eidx <= '0;
          improved <= 1'b0;
          state <= S_FETCH;
        end
        S_FETCH: begin
          if (eidx == ecount) begin
            eidx <= '0;
            if (check) begin
              vidx <= '0;
              state <= S_EMIT;
            end else begin
              pass <= pass + 7'd1;
            end
          end else begin
            ru <= e_src[eidx[bfsp_pkg::EW-1:0]];
            rv <= e_dst[eidx[bfsp_pkg::EW-1:0]];
            rw <= e_wt[eidx[bfsp_pkg::EW-1:0]];
            state <= S_READ;
          end
        end
        S_READ: begin
          dist_u <= dist_tab[ru];
          dist_v <= dist_tab[rv];
          state <= S_RELAX;
        end
        S_RELAX: begin
          if (better) begin
            if (check) improved <= 1'b1;
            else begin
              dist_tab[rv] <= cand;
              fin[rv] <= 1'b1;
              pred[rv] <= 7'({1'b0, ru});
            end
          end
          eidx <= eidx + 1'b1;
          state <= S_FETCH;
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            if (improved) begin
              vertex <= '0;
              reached <= 1'b0;
              distance <= '0;
              predecessor <= -7'sd1;
              negative_cycle <= 1'b1;
              last_result <= 1'b1;
              state <= S_WAIT;
            end else begin
              vertex <= vidx[bfsp_pkg::VW-1:0];
              reached <= fin[vidx[bfsp_pkg::VW-1:0]];
              distance <= fin[vidx[bfsp_pkg::VW-1:0]] ? dist_tab[vidx[bfsp_pkg::VW-1:0]] : '0;
              predecessor <= fin[vidx[bfsp_pkg::VW-1:0]] ? pred[vidx[bfsp_pkg::VW-1:0]]
                                                         : -7'sd1;
              negative_cycle <= 1'b0;
              last_result <= (7'(vidx) + 7'd1 == nv);
              vidx <= vidx + 1'b1;
              if (7'(vidx) + 7'd1 == nv) state <= S_WAIT;
            end
          end
        end
        S_WAIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            ecount <= '0;
            state <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

`include "bellman_ford_shortest_paths_assert.svh"
  `BFSP_ASSERT_IMPL(a_ecount_cap, clk, rst, 1'b1, ecount <= (bfsp_pkg::EW+1)'(bfsp_pkg::MaxEdges), "edge count over capacity")
  `BFSP_ASSERT_IMPL(a_no_out_load, clk, rst, state == S_LOAD, !out_valid, "result during load")
  `BFSP_ASSERT_IMPL(a_pass_range, clk, rst, state == S_RELAX, pass <= nv, "pass overrun")
endmodule

// ===== sv/bellman_ford_shortest_paths.sv =====
// Top level of the Bellman-Ford shortest-path block.
// Depends on bfsp_pkg, bfsp_front and bfsp_engine.
//
// Edges are loaded one transfer per cycle, while the engine is loading,
// into a two-entry queue and then into a 256-entry edge store. The
// transfer flagged last_edge starts a run: N-1 relaxation passes plus
// one negative-cycle check pass, with N the vertex_count clamped to
// 1..64; each pass reads every stored edge through the fetch, read and
// relax states. Loading stalls while a run is in progress. Results are
// one transfer per vertex, or one transfer flagging a negative cycle.
module bellman_ford_shortest_paths (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [6:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [5:0]         edge_source,
  input  logic [5:0]         edge_dest,
  input  logic signed [15:0] edge_weight,
  input  logic               edge_present,
  input  logic               last_edge,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         vertex,
  output logic               reached,
  output logic signed [23:0] distance,
  output logic signed [6:0]  predecessor,
  output logic               negative_cycle,
  output logic               last_result
);
  logic [6:0] vertex_count;
  logic [5:0] start_vertex;
  bfsp_pkg::edge_item_t in_item, q_item;
  logic q_valid, q_ready;

  // Configuration registers; the user must write them only while idle, which the block itself does not enforce.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= 7'd32;
      start_vertex <= 6'd0;
    end else if (cfg_we) begin
      if (cfg_index == bfsp_pkg::CfgVertexCount) vertex_count <= cfg_data;
      else start_vertex <= cfg_data[5:0];
    end
  end

  assign in_item = '{src: edge_source, dst: edge_dest, weight: edge_weight,
                     present: edge_present, last: last_edge};

  bfsp_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  bfsp_engine u_engine (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .vertex_count(vertex_count), .start_vertex(start_vertex),
    .out_valid(out_valid), .out_ready(out_ready), .vertex(vertex),
    .reached(reached), .distance(distance), .predecessor(predecessor),
    .negative_cycle(negative_cycle), .last_result(last_result)
  );
endmodule
